FILE: src/cwfi_pkg.sv
// Shared types and constants of the conductivity-weighted face interpolator.
// No dependencies; every module of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none
package cwfi_pkg;

    localparam int KIND_W = 2;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_INTERIOR = 2'd0;
    localparam t_kind KIND_PATCH    = 2'd1;

    // Width of one side weight (32 x 32 product) and of the doubled weight sum.
    localparam int PROD_W = 64;
    localparam int HALF_W = 32;
    localparam int DEN_W  = PROD_W + 2;

    // One in Q1.16, the complement base of the Q0.16 patch weight.
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // Control that travels with every pipeline slot.
    typedef struct packed {
        logic valid;
        logic err;
        logic pass;
    } t_ctrl;

endpackage
`default_nettype wire

FILE: src/cwfi_weight.sv
// First stage: side weights from conductivities, distances and patch weight.
// Depends on cwfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwfi_weight #(
    parameter int VALUE_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire cwfi_pkg::t_kind         i_kind,
    input  wire [VALUE_BITS-1:0]         i_vo,
    input  wire [VALUE_BITS-1:0]         i_vn,
    input  wire [31:0]                   i_co,
    input  wire [31:0]                   i_cn,
    input  wire [31:0]                   i_do,
    input  wire [31:0]                   i_dn,
    input  wire [15:0]                   i_w,
    output cwfi_pkg::t_ctrl              o_ctrl,
    output logic [VALUE_BITS-1:0]        o_vo_b,
    output logic [VALUE_BITS-1:0]        o_vn_b,
    output logic [cwfi_pkg::PROD_W-1:0]  o_wo,
    output logic [cwfi_pkg::PROD_W-1:0]  o_wn
);
    localparam logic [VALUE_BITS-1:0] BIAS = {1'b1, {(VALUE_BITS-1){1'b0}}};

    cwfi_pkg::t_ctrl             r_ctrl, n_ctrl;
    logic [VALUE_BITS-1:0]       r_vo_b, r_vn_b;
    logic [cwfi_pkg::PROD_W-1:0] r_wo, r_wn;
    logic [31:0]                 mul_o, mul_n;
    logic [16:0]                 w_comp;

    always_comb begin
        w_comp = cwfi_pkg::WEIGHT_ONE - {1'b0, i_w};
        n_ctrl.valid = i_valid;
        n_ctrl.pass  = (i_kind != cwfi_pkg::KIND_INTERIOR) && (i_kind != cwfi_pkg::KIND_PATCH);
        if (i_kind == cwfi_pkg::KIND_INTERIOR) begin
            mul_o     = i_dn;
            mul_n     = i_do;
            n_ctrl.err = (i_do == 32'd0) || (i_dn == 32'd0);
        end else begin
            mul_o     = {16'd0, i_w};
            mul_n     = {15'd0, w_comp};
            n_ctrl.err = !n_ctrl.pass && ((i_do == 32'd0) || (i_w == 16'd0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vo_b <= i_vo ^ BIAS;
            r_vn_b <= i_vn ^ BIAS;
            r_wo   <= {32'd0, i_co} * {32'd0, mul_o};
            r_wn   <= {32'd0, i_cn} * {32'd0, mul_n};
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_vo_b = r_vo_b;
    assign o_vn_b = r_vn_b;
    assign o_wo   = r_wo;
    assign o_wn   = r_wn;
endmodule
`default_nettype wire

FILE: src/cwfi_accum.sv
// Second and third stages: partial products, weight sum, then the rounded
// numerator 2*(vo*wo + vn*wn) + S and denominator 2*S. Depends on cwfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwfi_accum #(
    parameter int VALUE_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire cwfi_pkg::t_ctrl             i_ctrl,
    input  wire [VALUE_BITS-1:0]             i_vo_b,
    input  wire [VALUE_BITS-1:0]             i_vn_b,
    input  wire [cwfi_pkg::PROD_W-1:0]       i_wo,
    input  wire [cwfi_pkg::PROD_W-1:0]       i_wn,
    output cwfi_pkg::t_ctrl                  o_ctrl,
    output logic [VALUE_BITS-1:0]            o_vn_b,
    output logic [VALUE_BITS+cwfi_pkg::DEN_W:0] o_num,
    output logic [cwfi_pkg::DEN_W-1:0]       o_den
);
    localparam int HW = cwfi_pkg::HALF_W;
    localparam int PW = VALUE_BITS + HW;
    localparam int NW = VALUE_BITS + cwfi_pkg::DEN_W + 1;
    localparam int SW = cwfi_pkg::PROD_W + 1;

    cwfi_pkg::t_ctrl       r_ctrl_a, r_ctrl_b, n_ctrl_a;
    logic [VALUE_BITS-1:0] r_vn_a, r_vn_b;
    logic [PW-1:0]         r_po_lo, r_po_hi, r_pn_lo, r_pn_hi;
    logic [SW-1:0]         r_sum;
    logic [NW-1:0]         r_num, n_num;
    logic [cwfi_pkg::DEN_W-1:0] r_den;

    always_comb begin
        n_ctrl_a     = i_ctrl;
        // No conductivity on either side leaves nothing to divide by.
        n_ctrl_a.err = i_ctrl.err || ((i_wo == '0) && (i_wn == '0) && !i_ctrl.pass);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
            r_ctrl_b <= '0;
        end else if (i_en) begin
            r_ctrl_a <= n_ctrl_a;
            r_ctrl_b <= r_ctrl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vn_a  <= i_vn_b;
            r_po_lo <= {{HW{1'b0}}, i_vo_b} * {{VALUE_BITS{1'b0}}, i_wo[HW-1:0]};
            r_po_hi <= {{HW{1'b0}}, i_vo_b} * {{VALUE_BITS{1'b0}}, i_wo[2*HW-1:HW]};
            r_pn_lo <= {{HW{1'b0}}, i_vn_b} * {{VALUE_BITS{1'b0}}, i_wn[HW-1:0]};
            r_pn_hi <= {{HW{1'b0}}, i_vn_b} * {{VALUE_BITS{1'b0}}, i_wn[2*HW-1:HW]};
            r_sum   <= {1'b0, i_wo} + {1'b0, i_wn};
        end
    end

    always_comb begin
        n_num = ({{(NW-PW){1'b0}}, r_po_lo}
              + {{(NW-PW-HW){1'b0}}, r_po_hi, {HW{1'b0}}}
              + {{(NW-PW){1'b0}}, r_pn_lo}
              + {{(NW-PW-HW){1'b0}}, r_pn_hi, {HW{1'b0}}}) << 1;
        n_num = n_num + {{(NW-SW){1'b0}}, r_sum};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vn_b <= r_vn_a;
            r_num  <= n_num;
            r_den  <= {r_sum, 1'b0};
        end
    end

    assign o_ctrl = r_ctrl_b;
    assign o_vn_b = r_vn_b;
    assign o_num  = r_num;
    assign o_den  = r_den;
endmodule
`default_nettype wire

FILE: src/cwfi_div_stage.sv
// One restoring-division stage: resolves quotient bit BIT_IDX.
// Depends on cwfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwfi_div_stage #(
    parameter int VALUE_BITS = 32,
    parameter int BIT_IDX    = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire cwfi_pkg::t_ctrl         i_ctrl,
    input  wire [VALUE_BITS-1:0]         i_vn_b,
    input  wire [VALUE_BITS-1:0]         i_num_lo,
    input  wire [VALUE_BITS-1:0]         i_q,
    input  wire [cwfi_pkg::DEN_W-1:0]    i_rem,
    input  wire [cwfi_pkg::DEN_W-1:0]    i_den,
    output cwfi_pkg::t_ctrl              o_ctrl,
    output logic [VALUE_BITS-1:0]        o_vn_b,
    output logic [VALUE_BITS-1:0]        o_num_lo,
    output logic [VALUE_BITS-1:0]        o_q,
    output logic [cwfi_pkg::DEN_W-1:0]   o_rem,
    output logic [cwfi_pkg::DEN_W-1:0]   o_den
);
    localparam int DW = cwfi_pkg::DEN_W;

    cwfi_pkg::t_ctrl       r_ctrl;
    logic [VALUE_BITS-1:0] r_vn_b, r_num_lo, r_q, n_q;
    logic [DW-1:0]         r_rem, r_den, n_rem;
    logic [DW:0]           trial, diff;

    always_comb begin
        trial = {i_rem, i_num_lo[BIT_IDX]};
        diff  = trial - {1'b0, i_den};
        n_q   = i_q;
        if (!diff[DW]) begin
            n_rem        = diff[DW-1:0];
            n_q[BIT_IDX] = 1'b1;
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vn_b   <= i_vn_b;
            r_num_lo <= i_num_lo;
            r_q      <= n_q;
            r_rem    <= n_rem;
            r_den    <= i_den;
        end
    end

    assign o_ctrl   = r_ctrl;
    assign o_vn_b   = r_vn_b;
    assign o_num_lo = r_num_lo;
    assign o_q      = r_q;
    assign o_rem    = r_rem;
    assign o_den    = r_den;
endmodule
`default_nettype wire

FILE: src/conductivity_weighted_face_interp_core.sv
// Top level of the conductivity-weighted face interpolator: weight stage,
// accumulate stages, a chain of division stages and the output register.
// Depends on cwfi_pkg, cwfi_weight, cwfi_accum and cwfi_div_stage.
//
// Channel  Direction  Contents
// s_axis   in         tuser: face_kind; tdata: value_owner, value_neighbour,
//                     cond_owner, cond_neighbour, dist_owner, dist_neighbour,
//                     patch_weight
// m_axis   out        tdata: face_value; tuser: div_error
//
// One face request is taken every cycle while the pipeline is not held. A
// request passes through one weight stage, two accumulate stages, one
// division stage per quotient bit and the output register. Reset is
// synchronous and clears only the control bits (valid, err, pass). When
// the output register holds a result that is not taken, the whole pipeline
// holds still, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module conductivity_weighted_face_interp_core #(
    parameter int VALUE_BITS = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // value_owner, value_neighbour, cond_owner, cond_neighbour, dist_owner,
    // dist_neighbour, patch_weight, zero padding
    input  wire [((2*VALUE_BITS+144+7)/8)*8-1:0] i_s_axis_tdata,
    // face_kind
    input  wire [1:0]                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire                        i_m_axis_tready,
    // face_value, zero padding
    output logic [((VALUE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // div_error
    output logic [0:0]                 o_m_axis_tuser
);
    localparam int V   = VALUE_BITS;
    localparam int DW  = cwfi_pkg::DEN_W;
    localparam int NW  = V + DW + 1;
    localparam int OW  = ((V + 7) / 8) * 8;
    localparam logic [V-1:0] BIAS = {1'b1, {(V-1){1'b0}}};

    // The whole pipeline advances whenever the output slot is free or drained.
    logic pipe_en;

    cwfi_pkg::t_ctrl             ctrl_w, ctrl_a;
    logic [V-1:0]                vo_w, vn_w, vn_a;
    logic [cwfi_pkg::PROD_W-1:0] wo_w, wn_w;
    logic [NW-1:0]               num_a;
    logic [DW-1:0]               den_a;

    cwfi_pkg::t_ctrl ctrl_s [0:V];
    logic [V-1:0]    vn_s   [0:V];
    logic [V-1:0]    nlo_s  [0:V];
    logic [V-1:0]    q_s    [0:V];
    logic [DW-1:0]   rem_s  [0:V];
    logic [DW-1:0]   den_s  [0:V];

    cwfi_pkg::t_ctrl r_out_ctrl;
    logic [V-1:0]    r_out_data, n_out_data;

    assign pipe_en         = !r_out_ctrl.valid || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;

    cwfi_weight #(.VALUE_BITS(V)) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_s_axis_tvalid),
        .i_kind  (i_s_axis_tuser),
        .i_vo    (i_s_axis_tdata[V-1:0]),
        .i_vn    (i_s_axis_tdata[2*V-1:V]),
        .i_co    (i_s_axis_tdata[2*V+31:2*V]),
        .i_cn    (i_s_axis_tdata[2*V+63:2*V+32]),
        .i_do    (i_s_axis_tdata[2*V+95:2*V+64]),
        .i_dn    (i_s_axis_tdata[2*V+127:2*V+96]),
        .i_w     (i_s_axis_tdata[2*V+143:2*V+128]),
        .o_ctrl  (ctrl_w),
        .o_vo_b  (vo_w),
        .o_vn_b  (vn_w),
        .o_wo    (wo_w),
        .o_wn    (wn_w)
    );

    cwfi_accum #(.VALUE_BITS(V)) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_ctrl  (ctrl_w),
        .i_vo_b  (vo_w),
        .i_vn_b  (vn_w),
        .i_wo    (wo_w),
        .i_wn    (wn_w),
        .o_ctrl  (ctrl_a),
        .o_vn_b  (vn_a),
        .o_num   (num_a),
        .o_den   (den_a)
    );

    // The quotient fits in V bits because the face value lies between the
    // two cell values, so the top of the numerator is already below the
    // denominator and seeds the remainder directly.
    assign ctrl_s[0] = ctrl_a;
    assign vn_s[0]   = vn_a;
    assign nlo_s[0]  = num_a[V-1:0];
    assign q_s[0]    = '0;
    assign rem_s[0]  = num_a[NW-2:V];
    assign den_s[0]  = den_a;

    for (genvar g = 0; g < V; g++) begin : g_div
        cwfi_div_stage #(.VALUE_BITS(V), .BIT_IDX(V-1-g)) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (pipe_en),
            .i_ctrl   (ctrl_s[g]),
            .i_vn_b   (vn_s[g]),
            .i_num_lo (nlo_s[g]),
            .i_q      (q_s[g]),
            .i_rem    (rem_s[g]),
            .i_den    (den_s[g]),
            .o_ctrl   (ctrl_s[g+1]),
            .o_vn_b   (vn_s[g+1]),
            .o_num_lo (nlo_s[g+1]),
            .o_q      (q_s[g+1]),
            .o_rem    (rem_s[g+1]),
            .o_den    (den_s[g+1])
        );
    end

    // Boundary faces return the boundary value, failed divisions return zero,
    // everything else the rounded quotient taken back out of offset form.
    always_comb begin
        priority if (ctrl_s[V].pass) begin
            n_out_data = vn_s[V] ^ BIAS;
        end else if (ctrl_s[V].err) begin
            n_out_data = '0;
        end else begin
            n_out_data = q_s[V] ^ BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctrl <= '0;
        end else if (pipe_en) begin
            r_out_ctrl <= ctrl_s[V];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid   = r_out_ctrl.valid;
    assign o_m_axis_tdata    = {{(OW-V){1'b0}}, r_out_data};
    assign o_m_axis_tuser[0] = r_out_ctrl.err && !r_out_ctrl.pass;

    a_err_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_ctrl.valid && r_out_ctrl.err && !r_out_ctrl.pass) |-> (r_out_data == '0))
        else $error("failed division did not give zero");

    a_pass_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_w.valid && ctrl_w.pass) |-> !ctrl_w.err)
        else $error("boundary face flagged as division error");

    a_stall_freezes_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pipe_en && $past(i_rst_n)) |=> $stable(ctrl_s[V]))
        else $error("division chain moved during a stall");

    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_ctrl.valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
